@@ design/pfh_pkg.sv @@
// ----------------------------------------------------------------------------
// pfh_pkg
// Shared types, widths and a helper function of the pixel to floor mapper.
// ----------------------------------------------------------------------------
package pfh_pkg;

  localparam int COEF_FRAC_BITS  = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int PIX_FRAC_BITS   = 4;
  localparam int NUM_COEFS       = 9;

  localparam int COEF_W   = 48;
  localparam int PIX_W    = 16;
  localparam int COORD_W  = 32;
  localparam int IDX_W    = 4;
  localparam int REG_IDX_W = 3;

  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int NUM_W  = SUM_W + COORD_FRAC_BITS + 1;
  localparam int DEN_W  = SUM_W + 1;
  localparam int QW     = 33;
  localparam int RW     = DEN_W + QW;
  localparam int SAT_W  = QW + 3;
  localparam int DIFF_W = COORD_W + 1;
  localparam int LPROD_W = 2 * DIFF_W;

  localparam int DIV_LAT  = QW + 2;
  localparam int PIPE_LAT = 2 + DIV_LAT + 3 + DIV_LAT + 1;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic signed [DEN_W-1:0]   den_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SAT_W-1:0]   sat_t;

  localparam sat_t SAT_MAX = SAT_W'(32'sh7FFF_FFFF);
  localparam sat_t SAT_MIN = SAT_W'(32'sh8000_0000);

  typedef enum logic {
    OP_MAP  = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_FLOOR  = 2'd0,
    ST_HEIGHT = 2'd1,
    ST_UNCAL  = 2'd2,
    ST_ZERO_W = 2'd3
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CALIBRATED = 3'd0,
    REG_HEIGHT_EN  = 3'd1,
    REG_CAMERA_X   = 3'd2,
    REG_CAMERA_Y   = 3'd3,
    REG_CAMERA_Z   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    coord_t  h;
    coord_t  fx;
    coord_t  fz;
    status_e st;
    logic    wzero;
    logic    lift;
  } side_t;

  // Signs the quotient magnitude, adds an offset and saturates to 32 bits.
  function automatic coord_t div_sat(input logic ovf, input logic neg,
                                     input logic [QW-1:0] mag, input coord_t off);
    sat_t v;
    coord_t r;
    begin
      v = sat_t'({3'b000, mag});
      if (neg) begin
        v = -v;
      end
      v = v + sat_t'(off);
      if (ovf) begin
        r = neg ? SAT_MIN[COORD_W-1:0] : SAT_MAX[COORD_W-1:0];
      end else if (v > SAT_MAX) begin
        r = SAT_MAX[COORD_W-1:0];
      end else if (v < SAT_MIN) begin
        r = SAT_MIN[COORD_W-1:0];
      end else begin
        r = v[COORD_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

@@ design/pfh_div.sv @@
// ----------------------------------------------------------------------------
// pfh_div
// Pipelined signed divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module pfh_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  pfh_pkg::num_t             num_i,
  input  pfh_pkg::den_t             den_i,
  output logic                      valid_o,
  output logic                      ovf_o,
  output logic                      neg_o,
  output logic [pfh_pkg::QW-1:0]    mag_o
);

  logic                           va_q;
  logic [pfh_pkg::NUM_W-1:0]      an_q;
  logic [pfh_pkg::DEN_W-1:0]      dn_q;
  logic                           nega_q;

  logic                           v_q   [pfh_pkg::QW+1];
  logic [pfh_pkg::RW-1:0]         rem_q [pfh_pkg::QW+1];
  logic [pfh_pkg::DEN_W-1:0]      d_q   [pfh_pkg::QW+1];
  logic [pfh_pkg::QW-1:0]         q_q   [pfh_pkg::QW+1];
  logic                           neg_q [pfh_pkg::QW+1];
  logic                           ovf_q [pfh_pkg::QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q   <= num_i[pfh_pkg::NUM_W-1] ? pfh_pkg::NUM_W'(-num_i) : pfh_pkg::NUM_W'(num_i);
    dn_q   <= den_i[pfh_pkg::DEN_W-1] ? pfh_pkg::DEN_W'(-den_i) : pfh_pkg::DEN_W'(den_i);
    nega_q <= num_i[pfh_pkg::NUM_W-1] ^ den_i[pfh_pkg::DEN_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {{(pfh_pkg::RW-pfh_pkg::NUM_W){1'b0}}, an_q};
    d_q[0]   <= dn_q;
    q_q[0]   <= '0;
    neg_q[0] <= nega_q;
    ovf_q[0] <= {{(pfh_pkg::RW-pfh_pkg::NUM_W){1'b0}}, an_q} >=
                ({{pfh_pkg::QW{1'b0}}, dn_q} << pfh_pkg::QW);
  end

  for (genvar j = 0; j < pfh_pkg::QW; j++) begin : g_step
    localparam int SH = pfh_pkg::QW - 1 - j;
    logic [pfh_pkg::RW:0]     trial;
    logic [pfh_pkg::QW-1:0]   q_nx;

    assign trial = {1'b0, rem_q[j]} - ({{(pfh_pkg::QW+1){1'b0}}, d_q[j]} << SH);

    always_comb begin
      q_nx     = q_q[j];
      q_nx[SH] = ~trial[pfh_pkg::RW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]     <= trial[pfh_pkg::RW] ? rem_q[j] : trial[pfh_pkg::RW-1:0];
      q_q[j+1]       <= q_nx;
      d_q[j+1]       <= d_q[j];
      neg_q[j+1]     <= neg_q[j];
      ovf_q[j+1]     <= ovf_q[j];
    end
  end

  assign valid_o = v_q[pfh_pkg::QW];
  assign ovf_o   = ovf_q[pfh_pkg::QW];
  assign neg_o   = neg_q[pfh_pkg::QW];
  assign mag_o   = q_q[pfh_pkg::QW];

endmodule

@@ design/pfh_proj.sv @@
// ----------------------------------------------------------------------------
// pfh_proj
// Homography row products and row sums, two register stages.
// ----------------------------------------------------------------------------
module pfh_proj (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [pfh_pkg::PIX_W-1:0]  px_i,
  input  logic [pfh_pkg::PIX_W-1:0]  py_i,
  input  pfh_pkg::coord_t            h_i,
  input  pfh_pkg::coef_t             coef_i [pfh_pkg::NUM_COEFS],
  output logic                       valid_o,
  output pfh_pkg::sum_t              nx_o,
  output pfh_pkg::sum_t              nz_o,
  output pfh_pkg::sum_t              w_o,
  output pfh_pkg::coord_t            h_o
);

  logic signed [pfh_pkg::PIX_W:0] opnd [3];
  pfh_pkg::prod_t                 p_q  [pfh_pkg::NUM_COEFS];
  logic                           v1_q;
  pfh_pkg::coord_t                h1_q;
  logic                           v2_q;
  pfh_pkg::sum_t                  nx_q;
  pfh_pkg::sum_t                  nz_q;
  pfh_pkg::sum_t                  w_q;
  pfh_pkg::coord_t                h2_q;

  always_comb begin
    opnd[0] = $signed({1'b0, px_i});
    opnd[1] = $signed({1'b0, py_i});
    opnd[2] = (pfh_pkg::PIX_W+1)'(1 << pfh_pkg::PIX_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pfh_pkg::NUM_COEFS; k++) begin
      p_q[k] <= pfh_pkg::prod_t'(coef_i[k]) * pfh_pkg::prod_t'(opnd[k % 3]);
    end
    h1_q <= h_i;
    nx_q <= pfh_pkg::sum_t'(p_q[0]) + pfh_pkg::sum_t'(p_q[1]) + pfh_pkg::sum_t'(p_q[2]);
    nz_q <= pfh_pkg::sum_t'(p_q[3]) + pfh_pkg::sum_t'(p_q[4]) + pfh_pkg::sum_t'(p_q[5]);
    w_q  <= pfh_pkg::sum_t'(p_q[6]) + pfh_pkg::sum_t'(p_q[7]) + pfh_pkg::sum_t'(p_q[8]);
    h2_q <= h1_q;
  end

  assign valid_o = v2_q;
  assign nx_o    = nx_q;
  assign nz_o    = nz_q;
  assign w_o     = w_q;
  assign h_o     = h2_q;

endmodule

@@ design/pixel_to_floor_at_height.sv @@
// ----------------------------------------------------------------------------
// pixel_to_floor_at_height
// Maps a pixel through a 3x3 homography to floor coordinates, with an
// optional move along the camera ray to a plane at a given height.
//
//   Channel   Ports                                     Handshake
//   input     operation_i coef_index_i coef_value_i     start, busy
//             pixel_x_i pixel_y_i target_height_i
//   result    floor_x_o floor_z_o status_o              done_o strobe
//   config    cfg_idx_i cfg_wdata_i                     cfg_we_i
//
// One item is taken every cycle; busy stays low. A map item's result passes
// through two divider steps, each a pair of 35-stage dividers (one pair
// for the projection, one pair for the height correction). Load items
// write their coefficient at acceptance and give no result. Reset clears
// the coefficients, the registers and all valid bits. Nothing stalls.
// ----------------------------------------------------------------------------
module pixel_to_floor_at_height (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [pfh_pkg::IDX_W-1:0]     coef_index_i,
  input  logic signed [pfh_pkg::COEF_W-1:0] coef_value_i,
  input  logic [pfh_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [pfh_pkg::PIX_W-1:0]     pixel_y_i,
  input  logic signed [pfh_pkg::COORD_W-1:0] target_height_i,
  input  logic                          cfg_we_i,
  input  logic [pfh_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfh_pkg::COORD_W-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic signed [pfh_pkg::COORD_W-1:0] floor_x_o,
  output logic signed [pfh_pkg::COORD_W-1:0] floor_z_o,
  output logic [1:0]                    status_o
);

  logic acc;
  logic map_v;
  logic load_v;

  pfh_pkg::coef_t  coef_q [pfh_pkg::NUM_COEFS];
  logic            cal_q;
  logic            hm_q;
  pfh_pkg::coord_t cx_q;
  pfh_pkg::coord_t cy_q;
  pfh_pkg::coord_t cz_q;

  logic            pv;
  pfh_pkg::sum_t   nx;
  pfh_pkg::sum_t   nz;
  pfh_pkg::sum_t   w;
  pfh_pkg::coord_t ph;

  pfh_pkg::side_t  side_d;
  pfh_pkg::side_t  s1_q [pfh_pkg::DIV_LAT];

  logic                  d1x_v, d1x_ovf, d1x_neg;
  logic [pfh_pkg::QW-1:0] d1x_mag;
  logic                  d1z_v, d1z_ovf, d1z_neg;
  logic [pfh_pkg::QW-1:0] d1z_mag;

  logic            f_v_q;
  pfh_pkg::side_t  f_q;
  pfh_pkg::side_t  f_d;
  pfh_pkg::coord_t fx_d;
  pfh_pkg::coord_t fz_d;
  logic            lift_d;

  logic            l0_v_q;
  pfh_pkg::side_t  l0_q;
  logic signed [pfh_pkg::DIFF_W-1:0] dx_q, dz_q, m_q;

  logic            l1_v_q;
  pfh_pkg::side_t  l1_q;
  logic signed [pfh_pkg::LPROD_W-1:0] lx_q, lz_q;

  pfh_pkg::side_t  s2_q [pfh_pkg::DIV_LAT];

  logic                  d2x_v, d2x_ovf, d2x_neg;
  logic [pfh_pkg::QW-1:0] d2x_mag;
  logic                  d2z_v, d2z_ovf, d2z_neg;
  logic [pfh_pkg::QW-1:0] d2z_mag;

  logic            done_q;
  pfh_pkg::coord_t ox_q;
  pfh_pkg::coord_t oz_q;
  logic [1:0]      ost_q;
  pfh_pkg::coord_t ox_d;
  pfh_pkg::coord_t oz_d;

  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign map_v  = acc && (pfh_pkg::op_e'(operation_i) == pfh_pkg::OP_MAP);
  assign load_v = acc && (pfh_pkg::op_e'(operation_i) == pfh_pkg::OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pfh_pkg::NUM_COEFS; k++) begin
        coef_q[k] <= '0;
      end
    end else if (load_v && (coef_index_i < pfh_pkg::IDX_W'(pfh_pkg::NUM_COEFS))) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 1'b0;
      hm_q  <= 1'b0;
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (pfh_pkg::reg_idx_e'(cfg_idx_i))
        pfh_pkg::REG_CALIBRATED: cal_q <= cfg_wdata_i[0];
        pfh_pkg::REG_HEIGHT_EN:  hm_q  <= cfg_wdata_i[0];
        pfh_pkg::REG_CAMERA_X:   cx_q  <= cfg_wdata_i;
        pfh_pkg::REG_CAMERA_Y:   cy_q  <= cfg_wdata_i;
        pfh_pkg::REG_CAMERA_Z:   cz_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pfh_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (map_v),
    .px_i    (pixel_x_i),
    .py_i    (pixel_y_i),
    .h_i     (target_height_i),
    .coef_i  (coef_q),
    .valid_o (pv),
    .nx_o    (nx),
    .nz_o    (nz),
    .w_o     (w),
    .h_o     (ph)
  );

  always_comb begin
    side_d       = '0;
    side_d.h     = ph;
    side_d.st    = pfh_pkg::ST_FLOOR;
    side_d.wzero = (w == '0);
  end

  always_ff @(posedge clk_i) begin
    s1_q[0] <= side_d;
    for (int i = 1; i < pfh_pkg::DIV_LAT; i++) begin
      s1_q[i] <= s1_q[i-1];
    end
  end

  pfh_div u_div1x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv),
    .num_i   (pfh_pkg::num_t'(nx) <<< pfh_pkg::COORD_FRAC_BITS),
    .den_i   (pfh_pkg::den_t'(w)),
    .valid_o (d1x_v),
    .ovf_o   (d1x_ovf),
    .neg_o   (d1x_neg),
    .mag_o   (d1x_mag)
  );

  pfh_div u_div1z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv),
    .num_i   (pfh_pkg::num_t'(nz) <<< pfh_pkg::COORD_FRAC_BITS),
    .den_i   (pfh_pkg::den_t'(w)),
    .valid_o (d1z_v),
    .ovf_o   (d1z_ovf),
    .neg_o   (d1z_neg),
    .mag_o   (d1z_mag)
  );

  always_comb begin
    fx_d   = pfh_pkg::div_sat(d1x_ovf, d1x_neg, d1x_mag, '0);
    fz_d   = pfh_pkg::div_sat(d1z_ovf, d1z_neg, d1z_mag, '0);
    lift_d = hm_q && (s1_q[pfh_pkg::DIV_LAT-1].h != '0) && (cy_q != '0);
  end

  always_comb begin
    f_d      = s1_q[pfh_pkg::DIV_LAT-1];
    f_d.fx   = fx_d;
    f_d.fz   = fz_d;
    f_d.lift = lift_d;
    priority if (!cal_q) begin
      f_d.st = pfh_pkg::ST_UNCAL;
    end else if (s1_q[pfh_pkg::DIV_LAT-1].wzero) begin
      f_d.st = pfh_pkg::ST_ZERO_W;
    end else if (lift_d) begin
      f_d.st = pfh_pkg::ST_HEIGHT;
    end else begin
      f_d.st = pfh_pkg::ST_FLOOR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q  <= 1'b0;
      l0_v_q <= 1'b0;
      l1_v_q <= 1'b0;
    end else begin
      f_v_q  <= d1x_v && d1z_v;
      l0_v_q <= f_v_q;
      l1_v_q <= l0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q  <= f_d;

    l0_q <= f_q;
    dx_q <= pfh_pkg::DIFF_W'(f_q.fx) - pfh_pkg::DIFF_W'(cx_q);
    dz_q <= pfh_pkg::DIFF_W'(f_q.fz) - pfh_pkg::DIFF_W'(cz_q);
    m_q  <= pfh_pkg::DIFF_W'(cy_q) - pfh_pkg::DIFF_W'(f_q.h);

    l1_q <= l0_q;
    lx_q <= pfh_pkg::LPROD_W'(dx_q) * pfh_pkg::LPROD_W'(m_q);
    lz_q <= pfh_pkg::LPROD_W'(dz_q) * pfh_pkg::LPROD_W'(m_q);

    s2_q[0] <= l1_q;
    for (int i = 1; i < pfh_pkg::DIV_LAT; i++) begin
      s2_q[i] <= s2_q[i-1];
    end
  end

  pfh_div u_div2x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l1_v_q),
    .num_i   (pfh_pkg::num_t'(lx_q)),
    .den_i   (pfh_pkg::den_t'(cy_q)),
    .valid_o (d2x_v),
    .ovf_o   (d2x_ovf),
    .neg_o   (d2x_neg),
    .mag_o   (d2x_mag)
  );

  pfh_div u_div2z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l1_v_q),
    .num_i   (pfh_pkg::num_t'(lz_q)),
    .den_i   (pfh_pkg::den_t'(cy_q)),
    .valid_o (d2z_v),
    .ovf_o   (d2z_ovf),
    .neg_o   (d2z_neg),
    .mag_o   (d2z_mag)
  );

  always_comb begin
    unique case (s2_q[pfh_pkg::DIV_LAT-1].st)
      pfh_pkg::ST_FLOOR: begin
        ox_d = s2_q[pfh_pkg::DIV_LAT-1].fx;
        oz_d = s2_q[pfh_pkg::DIV_LAT-1].fz;
      end
      pfh_pkg::ST_HEIGHT: begin
        ox_d = pfh_pkg::div_sat(d2x_ovf, d2x_neg, d2x_mag, cx_q);
        oz_d = pfh_pkg::div_sat(d2z_ovf, d2z_neg, d2z_mag, cz_q);
      end
      default: begin
        ox_d = '0;
        oz_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2x_v && d2z_v;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q  <= ox_d;
    oz_q  <= oz_d;
    ost_q <= s2_q[pfh_pkg::DIV_LAT-1].st;
  end

  assign done_o    = done_q;
  assign floor_x_o = ox_q;
  assign floor_z_o = oz_q;
  assign status_o  = ost_q;

endmodule

@@ design/pfh_chk.sv @@
// ----------------------------------------------------------------------------
// pfh_chk
// Port-level checks of the pixel to floor mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pfh_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               operation_i,
  input logic                               done_o,
  input logic signed [pfh_pkg::COORD_W-1:0] floor_x_o,
  input logic signed [pfh_pkg::COORD_W-1:0] floor_z_o,
  input logic [1:0]                         status_o
);

  logic map_acc;

  assign map_acc = start && !busy && (operation_i == pfh_pkg::OP_MAP);

  a_map_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_acc |-> ##(pfh_pkg::PIPE_LAT) done_o)
    else $error("map item without result");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(map_acc, pfh_pkg::PIPE_LAT))
    else $error("result without map item");

  a_uncal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == pfh_pkg::ST_UNCAL) || (status_o == pfh_pkg::ST_ZERO_W)))
      |-> ((floor_x_o == '0) && (floor_z_o == '0)))
    else $error("nonzero coordinates on failed mapping");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

endmodule

bind pixel_to_floor_at_height pfh_chk u_pfh_chk (.*);
